// ===== src/sgls_pkg.sv =====
package sgls_pkg;

    localparam int MAX_FRAGMENTS_DEFAULT = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    localparam int TOTAL_W   = 32;
    localparam int ADDR_W    = 64;
    localparam int ELEN_W    = 17;
    localparam int FLEN_W    = 20;
    localparam int SPLIT_W   = 25;
    localparam int INDEX_W   = 16;
    localparam int MPL_W     = 11;
    localparam int DIV_W     = 20;
    localparam int DIV_CNT_W = 5;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 128;

    localparam logic [DIV_W-1:0]   BIG_SPLIT  = 20'd524288;
    localparam logic [SPLIT_W-1:0] PAGE_LIMIT = 25'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_TRANSFER_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PACKET    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EP_MAX_XFER   = 2'd2;

    localparam logic [1:0] TYPE_CONTROL   = 2'd0;
    localparam logic [1:0] TYPE_ISOCH     = 2'd1;
    localparam logic [1:0] TYPE_BULK      = 2'd2;

    localparam logic [1:0] ST_UNSPLIT = 2'd0;
    localparam logic [1:0] ST_SPLIT   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_UNSPLIT = 2'd1,
        MODE_SPLIT   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_DIVEND,
        S_FRAG
    } t_state;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_UNSPLIT,
        KIND_REFUSE,
        KIND_SPLIT_NEW,
        KIND_SPLIT_CONT
    } t_kind;

    typedef struct packed {
        logic load_in;
        logic emit_start;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic frag;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  div_last;
        logic  frag_more;
        logic  out_room;
    } t_sts;

endpackage

// ===== src/sgls_ctrl.sv =====
module sgls_ctrl
    import sgls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                unique case (i_sts.kind)
                    KIND_NONE: n_state = S_IDLE;
                    KIND_UNSPLIT, KIND_REFUSE: begin
                        if (i_sts.out_room) begin
                            n_state = S_IDLE;
                        end
                    end
                    KIND_SPLIT_NEW:  n_state = S_DIV;
                    KIND_SPLIT_CONT: n_state = S_FRAG;
                    default:         n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_DIVEND;
                end
            end
            S_DIVEND: n_state = S_FRAG;
            S_FRAG: begin
                if (i_sts.out_room && !i_sts.frag_more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_START: begin
                unique case (i_sts.kind)
                    KIND_UNSPLIT, KIND_REFUSE: o_cmd.emit_start = i_sts.out_room;
                    KIND_SPLIT_NEW:            o_cmd.div_start  = 1'b1;
                    default:                   o_cmd.emit_start = 1'b0;
                endcase
            end
            S_DIV:    o_cmd.div_step   = 1'b1;
            S_DIVEND: o_cmd.div_finish = 1'b1;
            S_FRAG:   o_cmd.frag       = i_sts.out_room;
            default:  o_cmd            = '0;
        endcase
    end

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_DIVEND))
        else $error("divider left early");

endmodule

// ===== src/sgls_datapath.sv =====
module sgls_datapath
    import sgls_pkg::*;
#(
    parameter int MAX_FRAGMENTS_PER_ENTRY = MAX_FRAGMENTS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_first_entry,
    input  logic [TOTAL_W-1:0]     i_total_length,
    input  logic [ADDR_W-1:0]      i_entry_address,
    input  logic [ELEN_W-1:0]      i_entry_length,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [ADDR_W-1:0]      o_frag_address,
    output logic [FLEN_W-1:0]      o_frag_length,
    output logic [FLEN_W-1:0]      o_offset_in_split,
    output logic [INDEX_W-1:0]     o_split_index,
    output logic                   o_last_of_split,
    output logic                   o_last_of_transfer,
    output logic [1:0]             o_status,
    output logic                   o_last,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts
);

    localparam int FW = (MAX_FRAGMENTS_PER_ENTRY > 2) ? $clog2(MAX_FRAGMENTS_PER_ENTRY) : 1;
    localparam logic [FW-1:0] LAST_FRAG = FW'(MAX_FRAGMENTS_PER_ENTRY - 1);

    logic [1:0]         r_cfg_type;
    logic [MPL_W-1:0]   r_cfg_mpl;
    logic [SPLIT_W-1:0] r_cfg_emt;

    logic               r_in_first;
    logic [TOTAL_W-1:0] r_in_total;
    logic [ADDR_W-1:0]  r_in_addr;
    logic [ELEN_W-1:0]  r_in_elen;

    logic [TOTAL_W-1:0] r_br;
    logic [SPLIT_W-1:0] r_split_room;
    logic [SPLIT_W-1:0] r_split_offset;
    logic [INDEX_W-1:0] r_split_number;
    logic [SPLIT_W-1:0] r_split_size;
    t_mode              r_mode;

    logic [ELEN_W-1:0]  r_pos;
    logic [FW-1:0]      r_nfrag;

    logic [DIV_W-1:0]     r_div_len;
    logic [DIV_W-1:0]     r_div_num;
    logic [MPL_W-1:0]     r_div_rem;
    logic [MPL_W-1:0]     r_div_mpl;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic               r_out_valid;

    t_kind              kind;
    logic [TOTAL_W-1:0] u_br;
    logic [SPLIT_W-1:0] u_off;
    logic               u_done;

    logic [DIV_W-1:0]   d_len;
    logic [MPL_W:0]     d_trial;
    logic [MPL_W-1:0]   d_rem;
    logic [DIV_W-1:0]   d_round;
    logic [DIV_W-1:0]   d_size;

    logic [ELEN_W-1:0]  f_avail;
    logic [ELEN_W-1:0]  f_len1;
    logic [ELEN_W-1:0]  f_len;
    logic [ELEN_W-1:0]  f_npos;
    logic [TOTAL_W-1:0] f_nrem;
    logic [SPLIT_W-1:0] f_room;
    logic               f_more;
    logic               f_limit;
    logic               f_ls;
    logic               f_lt;
    logic               out_room;

    always_comb begin
        if (r_in_first) begin
            if (r_in_total <= {7'd0, r_cfg_emt}) begin
                kind = KIND_UNSPLIT;
            end else if (r_cfg_type == TYPE_CONTROL || r_cfg_type == TYPE_ISOCH) begin
                kind = KIND_REFUSE;
            end else begin
                kind = KIND_SPLIT_NEW;
            end
        end else begin
            unique case (r_mode)
                MODE_UNSPLIT: kind = KIND_UNSPLIT;
                MODE_SPLIT:   kind = KIND_SPLIT_CONT;
                default:      kind = KIND_NONE;
            endcase
        end
    end

    assign u_br   = r_in_first ? r_in_total : r_br;
    assign u_off  = r_in_first ? '0 : r_split_offset;
    assign u_done = {15'd0, r_in_elen} >= u_br;

    assign d_len   = (r_cfg_emt <= PAGE_LIMIT) ? r_cfg_emt[DIV_W-1:0] : BIG_SPLIT;
    assign d_trial = {r_div_rem, r_div_num[DIV_W-1]};
    assign d_rem   = (d_trial >= {1'b0, r_div_mpl}) ? MPL_W'(d_trial - {1'b0, r_div_mpl})
                                                    : d_trial[MPL_W-1:0];
    assign d_round = r_div_len - {9'd0, r_div_rem};

    always_comb begin
        if (d_round != '0) begin
            d_size = d_round;
        end else if (r_div_len != '0) begin
            d_size = r_div_len;
        end else begin
            d_size = DIV_W'(1);
        end
    end

    assign f_avail = r_in_elen - r_pos;
    assign f_len1  = ({8'd0, f_avail} > r_split_room) ? r_split_room[ELEN_W-1:0] : f_avail;
    assign f_len   = ({15'd0, f_len1} > r_br) ? r_br[ELEN_W-1:0] : f_len1;
    assign f_npos  = r_pos + f_len;
    assign f_nrem  = r_br - {15'd0, f_len};
    assign f_more  = (f_nrem != '0) && (f_npos < r_in_elen);
    assign f_limit = f_more && (r_nfrag == LAST_FRAG);
    assign f_room  = r_split_room - {8'd0, f_len};
    assign f_lt    = (f_nrem == '0);
    assign f_ls    = (f_room == '0) || f_lt;

    assign out_room = !r_out_valid || i_out_ready;

    assign o_sts.kind      = kind;
    assign o_sts.div_last  = (r_div_cnt == DIV_CNT_W'(DIV_W - 1));
    assign o_sts.frag_more = f_more && !f_limit;
    assign o_sts.out_room  = out_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_type <= TYPE_BULK;
            r_cfg_mpl  <= 11'd64;
            r_cfg_emt  <= 25'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TRANSFER_TYPE: r_cfg_type <= i_cfg_data[1:0];
                REG_MAX_PACKET:    r_cfg_mpl  <= i_cfg_data[MPL_W-1:0];
                REG_EP_MAX_XFER:   r_cfg_emt  <= i_cfg_data;
                default:           r_cfg_type <= r_cfg_type;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_first <= i_first_entry;
            r_in_total <= i_total_length;
            r_in_addr  <= i_entry_address;
            r_in_elen  <= i_entry_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_len <= d_len;
            r_div_num <= d_len;
            r_div_rem <= '0;
            r_div_mpl <= (r_cfg_mpl == '0) ? MPL_W'(1) : r_cfg_mpl;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[DIV_W-2:0], 1'b0};
            r_div_rem <= d_rem;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_br           <= '0;
            r_split_room   <= '0;
            r_split_offset <= '0;
            r_split_number <= '0;
            r_split_size   <= '0;
            r_mode         <= MODE_IDLE;
            r_pos          <= '0;
            r_nfrag        <= '0;
        end else begin
            priority if (i_cmd.load_in) begin
                r_pos   <= '0;
                r_nfrag <= '0;
            end else if (i_cmd.emit_start) begin
                if (kind == KIND_REFUSE) begin
                    r_mode         <= MODE_IDLE;
                    r_br           <= '0;
                    r_split_offset <= '0;
                    r_split_number <= '0;
                end else begin
                    r_br           <= u_done ? '0 : u_br - {15'd0, r_in_elen};
                    r_split_offset <= u_off + {8'd0, r_in_elen};
                    r_mode         <= u_done ? MODE_IDLE : MODE_UNSPLIT;
                    if (r_in_first) begin
                        r_split_number <= '0;
                        r_split_room   <= '0;
                    end
                end
            end else if (i_cmd.div_start) begin
                r_split_offset <= '0;
                r_split_number <= '0;
                r_br           <= r_in_total;
            end else if (i_cmd.div_finish) begin
                r_split_size <= {5'd0, d_size};
                r_split_room <= {5'd0, d_size};
                r_mode       <= MODE_SPLIT;
            end else if (i_cmd.frag) begin
                if (f_limit) begin
                    r_mode <= MODE_IDLE;
                    r_br   <= '0;
                end else begin
                    r_br    <= f_nrem;
                    r_pos   <= f_npos;
                    r_nfrag <= r_nfrag + FW'(1);
                    if (f_ls) begin
                        r_split_room   <= r_split_size;
                        r_split_offset <= '0;
                        r_split_number <= r_split_number + INDEX_W'(1);
                    end else begin
                        r_split_room   <= f_room;
                        r_split_offset <= r_split_offset + {8'd0, f_len};
                    end
                    if (f_lt) begin
                        r_mode <= MODE_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_start || i_cmd.frag) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            o_last <= 1'b1;
            if (kind == KIND_REFUSE) begin
                o_frag_address     <= '0;
                o_frag_length      <= '0;
                o_offset_in_split  <= '0;
                o_split_index      <= '0;
                o_last_of_split    <= 1'b0;
                o_last_of_transfer <= 1'b0;
                o_status           <= ST_REFUSED;
            end else begin
                o_frag_address     <= r_in_addr;
                o_frag_length      <= {3'd0, r_in_elen};
                o_offset_in_split  <= u_off[FLEN_W-1:0];
                o_split_index      <= '0;
                o_last_of_split    <= u_done;
                o_last_of_transfer <= u_done;
                o_status           <= ST_UNSPLIT;
            end
        end else if (i_cmd.frag) begin
            if (f_limit) begin
                o_frag_address     <= '0;
                o_frag_length      <= '0;
                o_offset_in_split  <= '0;
                o_split_index      <= '0;
                o_last_of_split    <= 1'b0;
                o_last_of_transfer <= 1'b0;
                o_status           <= ST_LIMIT;
                o_last             <= 1'b1;
            end else begin
                o_frag_address     <= {r_in_addr[63:32], r_in_addr[31:0] + {15'd0, r_pos}};
                o_frag_length      <= {3'd0, f_len};
                o_offset_in_split  <= r_split_offset[FLEN_W-1:0];
                o_split_index      <= r_split_number;
                o_last_of_split    <= f_ls;
                o_last_of_transfer <= f_lt;
                o_status           <= ST_SPLIT;
                o_last             <= !f_more;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    a_room_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.frag |-> (r_split_room != '0))
        else $error("fragment issued with no room left in the split");

    a_transfer_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.frag && !f_limit && f_lt) |=> (r_mode == MODE_IDLE))
        else $error("transfer did not end after its final fragment");

    a_abort_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_status == ST_REFUSED || o_status == ST_LIMIT))
        |-> (o_last && o_frag_address == '0 && o_frag_length == '0))
        else $error("abort result carries payload");

endmodule

// ===== src/sg_list_transfer_splitter_core.sv =====
// Scatter-gather transfer splitter.
// Input stream: one scatter-gather entry per request. tuser carries the
// first-entry mark; tdata carries the total length, entry address and entry
// length. The configuration channel writes the transfer type, the maximum
// packet size and the endpoint maximum transfer; it is always ready and must
// only be used while no entry is in flight.
// Output stream: one request per fragment. tuser carries the status code,
// tlast marks the final fragment produced for an entry.
// An unsplit entry is captured in the input registers and then written to the output
// register once it has room; only then is the next entry taken. An entry that starts
// a split transfer first runs a bit-serial remainder unit for the split size; after that
// fragments leave at one per cycle while the receiver keeps up, up to the per-entry limit.
// The input is taken again once the last fragment of an entry sits in the
// output register, so a new entry may be accepted while it waits.
// When the receiver stalls, the output register holds its request and the
// fragment loop waits. Synchronous active-low reset returns the configuration and
// control registers to their defaults and leaves the block idle with nothing pending.
module sg_list_transfer_splitter_core
    import sgls_pkg::*;
#(
    parameter int MAX_FRAGMENTS_PER_ENTRY = MAX_FRAGMENTS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // total_length [31:0], entry_address [95:32], entry_length [112:96]
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // first_entry [0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // frag_address [63:0], frag_length [83:64], offset_in_split [103:84],
    // split_index [119:104], last_of_split [120], last_of_transfer [121]
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]             o_m_axis_tuser,
    output logic                   o_m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    logic [ADDR_W-1:0]  frag_address;
    logic [FLEN_W-1:0]  frag_length;
    logic [FLEN_W-1:0]  offset_in_split;
    logic [INDEX_W-1:0] split_index;
    logic               last_of_split;
    logic               last_of_transfer;

    assign o_cfg_ready = 1'b1;

    sgls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sgls_datapath #(
        .MAX_FRAGMENTS_PER_ENTRY (MAX_FRAGMENTS_PER_ENTRY)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_first_entry      (i_s_axis_tuser),
        .i_total_length     (i_s_axis_tdata[31:0]),
        .i_entry_address    (i_s_axis_tdata[95:32]),
        .i_entry_length     (i_s_axis_tdata[112:96]),
        .i_out_ready        (i_m_axis_tready),
        .o_out_valid        (o_m_axis_tvalid),
        .o_frag_address     (frag_address),
        .o_frag_length      (frag_length),
        .o_offset_in_split  (offset_in_split),
        .o_split_index      (split_index),
        .o_last_of_split    (last_of_split),
        .o_last_of_transfer (last_of_transfer),
        .o_status           (o_m_axis_tuser),
        .o_last             (o_m_axis_tlast),
        .i_cmd              (cmd),
        .o_sts              (sts)
    );

    assign o_m_axis_tdata = {6'd0, last_of_transfer, last_of_split, split_index,
                             offset_in_split, frag_length, frag_address};

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import sgls_pkg::*;
;

    localparam logic [1:0] TYPE_INTERRUPT = 2'd3;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 130;

    typedef struct {
        logic [63:0] addr;
        logic [19:0] flen;
        logic [19:0] offset;
        logic [15:0] index;
        logic        split_end;
        logic        xfer_end;
        logic [1:0]  status;
        logic        entry_end;
    } t_frag;

    class split_scoreboard;
        logic [1:0]  xfer_type  = TYPE_BULK;
        logic [10:0] pkt_len    = 11'd64;
        logic [24:0] ep_max     = 25'd4096;
        logic [31:0] bytes_left = '0;
        logic [24:0] room       = '0;
        logic [24:0] split_off  = '0;
        logic [24:0] split_sz   = '0;
        logic [15:0] split_num  = '0;
        t_mode       mode       = MODE_IDLE;
        t_frag       due[$];
        int          errors     = 0;

        function int pending();
            return due.size();
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_TRANSFER_TYPE: xfer_type = value[1:0];
                REG_MAX_PACKET: pkt_len = value[10:0];
                REG_EP_MAX_XFER: ep_max = value;
                default: ;
            endcase
        endfunction

        function void push(logic [63:0] addr, logic [19:0] flen, logic [19:0] offset,
                           logic [15:0] index, logic split_end, logic xfer_end,
                           logic [1:0] status, logic entry_end);
            due.push_back('{addr, flen, offset, index, split_end, xfer_end, status, entry_end});
        endfunction

        // Works out the fragments that one accepted entry produces.
        function int note_entry(logic first, logic [31:0] total, logic [63:0] addr,
                                logic [16:0] elen);
            logic [31:0] seg, pkt, rounded, chunk, pos, npos, nrem;
            logic        split_end, xfer_end, more;
            int          n;
            pos = '0;
            n = 0;
            if (first) begin
                split_off = '0;
                split_num = '0;
                bytes_left = total;
                if (total <= 32'(ep_max)) begin
                    mode = MODE_UNSPLIT;
                    room = '0;
                end else if (xfer_type == TYPE_CONTROL || xfer_type == TYPE_ISOCH) begin
                    mode = MODE_IDLE;
                    bytes_left = '0;
                    push('0, '0, '0, '0, 1'b0, 1'b0, ST_REFUSED, 1'b1);
                    return 1;
                end else begin
                    seg = (ep_max <= PAGE_LIMIT) ? 32'(ep_max) : 32'(BIG_SPLIT);
                    pkt = (pkt_len == 0) ? 32'd1 : 32'(pkt_len);
                    rounded = (seg / pkt) * pkt;
                    if (rounded == 0) rounded = seg;
                    if (rounded == 0) rounded = 32'd1;
                    split_sz = rounded[24:0];
                    room = split_sz;
                    mode = MODE_SPLIT;
                end
            end
            if (mode == MODE_UNSPLIT) begin
                split_end = (32'(elen) >= bytes_left);
                bytes_left = split_end ? 32'd0 : bytes_left - 32'(elen);
                push(addr, 20'(elen), split_off[19:0], 16'd0, split_end, split_end,
                     ST_UNSPLIT, 1'b1);
                split_off = split_off + 25'(elen);
                if (split_end) mode = MODE_IDLE;
                return 1;
            end
            if (mode != MODE_SPLIT) return 0;
            do begin
                chunk = 32'(elen) - pos;
                if (chunk > 32'(room)) chunk = 32'(room);
                if (chunk > bytes_left) chunk = bytes_left;
                npos = pos + chunk;
                nrem = bytes_left - chunk;
                more = (nrem != 0) && (npos < 32'(elen));
                if (more && n == MAX_FRAGMENTS_DEFAULT - 1) begin
                    push('0, '0, '0, '0, 1'b0, 1'b0, ST_LIMIT, 1'b1);
                    mode = MODE_IDLE;
                    bytes_left = '0;
                    return n + 1;
                end
                room = room - chunk[24:0];
                split_end = (room == 0) || (nrem == 0);
                xfer_end = (nrem == 0);
                push({addr[63:32], addr[31:0] + pos}, chunk[19:0], split_off[19:0], split_num,
                     split_end, xfer_end, ST_SPLIT, !more);
                n++;
                split_off = split_off + chunk[24:0];
                bytes_left = nrem;
                pos = npos;
                if (split_end) begin
                    split_num++;
                    room = split_sz;
                    split_off = '0;
                end
                if (xfer_end) mode = MODE_IDLE;
            end while (more);
            return n;
        endfunction

        task report(string msg);
            if (errors < 100) $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_fragment(t_frag got);
            t_frag want;
            if (due.size() == 0) begin
                report($sformatf("fragment with nothing due, address %h", got.addr));
                return;
            end
            want = due.pop_front();
            if (got.addr != want.addr)
                report($sformatf("frag_address %h, due %h", got.addr, want.addr));
            if (got.flen != want.flen)
                report($sformatf("frag_length %0d, due %0d", got.flen, want.flen));
            if (got.offset != want.offset)
                report($sformatf("offset_in_split %0d, due %0d", got.offset, want.offset));
            if (got.index != want.index)
                report($sformatf("split_index %0d, due %0d", got.index, want.index));
            if (got.split_end != want.split_end)
                report($sformatf("last_of_split %b, due %b", got.split_end, want.split_end));
            if (got.xfer_end != want.xfer_end)
                report($sformatf("last_of_transfer %b, due %b", got.xfer_end, want.xfer_end));
            if (got.status != want.status)
                report($sformatf("status %0d, due %0d", got.status, want.status));
            if (got.entry_end != want.entry_end)
                report($sformatf("tlast %b, due %b", got.entry_end, want.entry_end));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic [1:0]             o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    split_scoreboard board = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int ep_now = 4096;
    int live_items = 0;
    int quiet_cycles = 0;
    int random_start;
    int phase;

    sg_list_transfer_splitter_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_fragment('{o_m_axis_tdata[63:0], o_m_axis_tdata[83:64],
                                   o_m_axis_tdata[103:84], o_m_axis_tdata[119:104],
                                   o_m_axis_tdata[120], o_m_axis_tdata[121],
                                   o_m_axis_tuser, o_m_axis_tlast});
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand_addr();
        logic [63:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(4) == 0) a[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));
        return a;
    endfunction

    function automatic logic [16:0] pick_length();
        case ($urandom_range(9))
            0: return 17'($urandom_range(0, 16));
            1: return 17'd65536;
            2, 3: return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic send_entry(input logic first, input logic [31:0] total,
                              input logic [63:0] addr, input logic [16:0] elen);
        int n;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= first;
        i_s_axis_tdata <= {7'd0, elen, addr, total};
        do @(posedge i_clk); while (!o_s_axis_tready);
        n = board.note_entry(first, total, addr, elen);
        if (n > 0) live_items++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [1:0] kind, input logic [10:0] pkt,
                             input logic [24:0] ep);
        write_reg(REG_TRANSFER_TYPE, 25'(kind));
        write_reg(REG_MAX_PACKET, 25'(pkt));
        write_reg(REG_EP_MAX_XFER, ep);
        i_cfg_valid <= 1'b0;
        ep_now = ep;
    endtask

    // Stops the sender until every due fragment is out and the block has gone quiet.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_transfer();
        logic [31:0] total, left;
        logic [16:0] elen;
        int          n_entries;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 10)
            total = $urandom;
        else if (pick < 45)
            total = 32'($urandom_range(0, ep_now));
        else
            total = 32'(ep_now) + 32'd1 + 32'($urandom_range(0, 12000));
        left = total;
        n_entries = $urandom_range(1, 6);
        for (int k = 0; k < n_entries; k++) begin
            elen = pick_length();
            if (left <= 32'd65536 && $urandom_range(3) == 0)
                elen = left[16:0];
            else if (32'(elen) > left && $urandom_range(9) != 0)
                elen = left[16:0];
            send_entry(k == 0, (k == 0) ? total : 32'($urandom), rand_addr(), elen);
            left = (32'(elen) >= left) ? 32'd0 : left - 32'(elen);
            if (left == 0) break;
        end
        if ($urandom_range(9) == 0) send_entry(1'b0, $urandom, rand_addr(), pick_length());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_entry(1'b0, 32'd0, rand_addr(), 17'd100);
        send_entry(1'b1, 32'd4096, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65536);
        send_entry(1'b1, 32'd300, rand_addr(), 17'd100);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd100);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd100);
        send_entry(1'b1, 32'd150, rand_addr(), 17'd100);
        send_entry(1'b0, 32'hFFFF_FFFF, rand_addr(), 17'd200);
        send_entry(1'b1, 32'd0, 64'd0, 17'd0);
        send_entry(1'b1, 32'd10000, 64'h1234_5678_FFFF_F000, 17'd65536);
        send_entry(1'b1, 32'hFFFF_FFFF, rand_addr(), 17'd0);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd5000);
        send_entry(1'b1, 32'd5000, rand_addr(), 17'd4000);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd4000);
        send_entry(1'b1, 32'd8000, rand_addr(), 17'd1000);
        send_entry(1'b1, 32'd200, rand_addr(), 17'd50);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd150);
        // The split size must stay as it was when the transfer started.
        send_entry(1'b1, 32'd10000, rand_addr(), 17'd3000);
        settle();
        configure(TYPE_BULK, 11'd16, 25'd1000);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd7000);
        settle();
        configure(TYPE_INTERRUPT, 11'd64, 25'd64);
        send_entry(1'b1, 32'd100000, rand_addr(), 17'd65536);
        send_entry(1'b0, 32'd0, rand_addr(), 17'd100);
        settle();
        configure(TYPE_CONTROL, 11'd64, 25'd4096);
        send_entry(1'b1, 32'd4097, rand_addr(), 17'd10);
        send_entry(1'b1, 32'd4096, rand_addr(), 17'd10);
        settle();
        configure(TYPE_ISOCH, 11'd1024, 25'd4096);
        send_entry(1'b1, 32'hFFFF_FFFF, rand_addr(), 17'd10);
        settle();
        configure(TYPE_BULK, 11'd0, 25'd100);
        send_entry(1'b1, 32'd1000, rand_addr(), 17'd1000);
        settle();
        configure(TYPE_BULK, 11'd1024, 25'd100);
        send_entry(1'b1, 32'd300, rand_addr(), 17'd300);
        settle();
        configure(TYPE_INTERRUPT, 11'd7, 25'd0);
        send_entry(1'b1, 32'd10, rand_addr(), 17'd10);

        random_start = live_items;
        phase = 0;
        while (live_items - random_start < RANDOM_ITEMS) begin
            settle();
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            case (phase % 8)
                0: configure(TYPE_BULK, 11'd64, 25'd4096);
                1: configure(TYPE_INTERRUPT, 11'd1024, 25'd16777216);
                2: configure(TYPE_BULK, 11'd1, 25'd1);
                3: configure(TYPE_INTERRUPT, 11'($urandom_range(1, 1024)),
                             25'($urandom_range(1, 4096)));
                4: configure(TYPE_CONTROL, 11'($urandom_range(1, 1024)),
                             25'($urandom_range(1, 4096)));
                5: configure(TYPE_ISOCH, 11'($urandom_range(1, 1024)),
                             25'($urandom_range(1, 16777216)));
                6: configure(TYPE_BULK, 11'($urandom_range(1, 1024)),
                             25'($urandom_range(4097, 16777216)));
                default: configure(2'($urandom_range(0, 3)), 11'($urandom_range(1, 1024)),
                                   25'($urandom_range(1, 8192)));
            endcase
            repeat (4) run_transfer();
            phase++;
        end

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/sgls_pkg.sv
src/sgls_ctrl.sv
src/sgls_datapath.sv
src/sg_list_transfer_splitter_core.sv
dv/testbench.sv
